### design/epfl_pkg.sv
// Shared constants and controller types for the entry pool free-list unit.
`default_nettype none
package epfl_pkg;

    localparam int SP_SLOTS  = 128;
    localparam int TR_SLOTS  = 32;
    localparam int SP_IDX_W  = $clog2(SP_SLOTS);
    localparam int SP_LINK_W = $clog2(SP_SLOTS + 1);
    localparam int TR_IDX_W  = $clog2(TR_SLOTS);
    localparam int TR_LINK_W = $clog2(TR_SLOTS + 1);

    localparam int OP_W        = 2;
    localparam int ENTRY_W     = 7;
    localparam int ENTRY_CMP_W = ENTRY_W + 1;
    localparam int SLOT_W      = 7;
    localparam int STATUS_W    = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_REINIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

### design/entry_pool_free_list_unit.sv
// Top level of the entry pool free-list unit: controller plus datapath.
//
//  channel  | signals                         | contents
//  ---------+---------------------------------+------------------------------------------
//  s_ (in)  | s_tvalid s_tready s_tdata[15:0] | tdata: opcode[1:0] entry_index[8:2]
//           | s_tuser                         | tuser: pool_select
//  m_ (out) | m_tvalid m_tready m_tdata[15:0] | tdata: slot[6:0] status[8:7]
//
// Each item is accepted in S_IDLE while the link memory is read at the pool head, then
// committed in S_COMMIT, which updates the head/link state and loads the result register.
// Commit waits while the result register holds an item not yet taken.
// Reset (aresetn low, synchronous) rebuilds both free lists at once through
// per-entry link valid bits; no clearing pass is needed.
`default_nettype none
module entry_pool_free_list_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // opcode[1:0], entry_index[8:2], zeros above
    input  wire logic [epfl_pkg::IN_DATA_W-1:0]    s_tdata,
    // pool_select
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // slot[6:0], status[8:7], zeros above
    output logic [epfl_pkg::OUT_DATA_W-1:0]        m_tdata
);

    epfl_pkg::dp_cmd_t  cmd;
    epfl_pkg::dp_stat_t stat;

    epfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epfl_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

### design/epfl_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module epfl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/epfl_ctrl.sv
// Controller: accepts one item, then commits it once the result register is free.
`default_nettype none
module epfl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire epfl_pkg::dp_stat_t stat,
    output epfl_pkg::dp_cmd_t       cmd
);

    epfl_pkg::state_t state_reg;
    epfl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= epfl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            epfl_pkg::S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = epfl_pkg::S_COMMIT;
                end
            end
            epfl_pkg::S_COMMIT: begin
                // link read of the head is ready here
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = epfl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = epfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### design/epfl_datapath.sv
// Datapath: pool heads, link memories, link valid bits and the result register.
`default_nettype none
module epfl_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [epfl_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                                s_tuser,
    input  wire epfl_pkg::dp_cmd_t                   cmd,
    output epfl_pkg::dp_stat_t                       stat,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [epfl_pkg::OUT_DATA_W-1:0]          m_tdata
);

    localparam int SP_IW  = epfl_pkg::SP_IDX_W;
    localparam int SP_LW  = epfl_pkg::SP_LINK_W;
    localparam int TR_IW  = epfl_pkg::TR_IDX_W;
    localparam int TR_LW  = epfl_pkg::TR_LINK_W;
    localparam int CMP_W  = epfl_pkg::ENTRY_CMP_W;
    localparam int SLOT_W = epfl_pkg::SLOT_W;
    localparam int OUT_W  = epfl_pkg::OUT_DATA_W;
    localparam logic [SP_LW-1:0] SP_END = SP_LW'(epfl_pkg::SP_SLOTS);
    localparam logic [TR_LW-1:0] TR_END = TR_LW'(epfl_pkg::TR_SLOTS);

    // latched item
    logic [epfl_pkg::OP_W-1:0]    op_reg;
    logic                         pool_reg;
    logic [epfl_pkg::ENTRY_W-1:0] idx_reg;

    logic [SP_LW-1:0] sp_head_reg, sp_head_next;
    logic [TR_LW-1:0] tr_head_reg, tr_head_next;
    logic [epfl_pkg::SP_SLOTS-1:0] sp_vld_reg, sp_vld_next;
    logic [epfl_pkg::TR_SLOTS-1:0] tr_vld_reg, tr_vld_next;
    logic sp_vrd_reg;
    logic tr_vrd_reg;

    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic [SP_IW-1:0] sp_raddr, sp_waddr;
    logic [SP_LW-1:0] sp_rdata, sp_wdata, sp_link;
    logic             sp_we, sp_empty;
    logic [TR_IW-1:0] tr_raddr, tr_waddr;
    logic [TR_LW-1:0] tr_rdata, tr_wdata, tr_link;
    logic             tr_we, tr_empty;

    logic [CMP_W-1:0]              idx_ext;
    logic [SLOT_W-1:0]             slot;
    logic [epfl_pkg::STATUS_W-1:0] status;

    assign sp_raddr = sp_head_reg[SP_IW-1:0];
    assign tr_raddr = tr_head_reg[TR_IW-1:0];

    epfl_ram #(.DEPTH(epfl_pkg::SP_SLOTS), .WIDTH(SP_LW)) u_sp_links (
        .aclk  (aclk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    epfl_ram #(.DEPTH(epfl_pkg::TR_SLOTS), .WIDTH(TR_LW)) u_tr_links (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    assign stat.out_free = !m_tvalid_reg || m_tready;

    // an entry never written since rebuild holds its own index plus one
    assign sp_link  = sp_vrd_reg ? sp_rdata : sp_head_reg + SP_LW'(1);
    assign tr_link  = tr_vrd_reg ? tr_rdata : tr_head_reg + TR_LW'(1);
    assign sp_empty = sp_head_reg >= SP_END;
    assign tr_empty = tr_head_reg >= TR_END;
    assign idx_ext  = CMP_W'(idx_reg);

    always_comb begin
        sp_head_next = sp_head_reg;
        tr_head_next = tr_head_reg;
        sp_vld_next  = sp_vld_reg;
        tr_vld_next  = tr_vld_reg;
        sp_we        = 1'b0;
        tr_we        = 1'b0;
        sp_waddr     = sp_raddr;
        tr_waddr     = tr_raddr;
        sp_wdata     = SP_END;
        tr_wdata     = TR_END;
        slot         = '0;
        status       = epfl_pkg::STAT_OK;
        case (op_reg)
            epfl_pkg::OP_ALLOC: begin
                if (!pool_reg) begin
                    if (sp_empty) begin
                        status = epfl_pkg::STAT_EMPTY;
                    end else begin
                        slot                  = SLOT_W'(sp_head_reg);
                        sp_head_next          = sp_link;
                        sp_we                 = 1'b1;
                        sp_vld_next[sp_raddr] = 1'b1;
                    end
                end else begin
                    if (tr_empty) begin
                        status = epfl_pkg::STAT_EMPTY;
                    end else begin
                        slot                  = SLOT_W'(tr_head_reg);
                        tr_head_next          = tr_link;
                        tr_we                 = 1'b1;
                        tr_vld_next[tr_raddr] = 1'b1;
                    end
                end
            end
            epfl_pkg::OP_RELEASE: begin
                if (!pool_reg) begin
                    if (idx_ext >= CMP_W'(epfl_pkg::SP_SLOTS)) begin
                        status = epfl_pkg::STAT_RANGE;
                    end else begin
                        sp_waddr              = idx_reg[SP_IW-1:0];
                        sp_wdata              = sp_head_reg;
                        sp_we                 = 1'b1;
                        sp_vld_next[sp_waddr] = 1'b1;
                        sp_head_next          = SP_LW'(idx_reg);
                    end
                end else begin
                    if (idx_ext >= CMP_W'(epfl_pkg::TR_SLOTS)) begin
                        status = epfl_pkg::STAT_RANGE;
                    end else begin
                        tr_waddr              = idx_reg[TR_IW-1:0];
                        tr_wdata              = tr_head_reg;
                        tr_we                 = 1'b1;
                        tr_vld_next[tr_waddr] = 1'b1;
                        tr_head_next          = TR_LW'(idx_reg);
                    end
                end
            end
            epfl_pkg::OP_REINIT: begin
                sp_head_next = '0;
                tr_head_next = '0;
                sp_vld_next  = '0;
                tr_vld_next  = '0;
            end
            default: begin
            end
        endcase
        if (!cmd.commit) begin
            sp_we = 1'b0;
            tr_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tdata[epfl_pkg::OP_W-1:0];
            pool_reg <= s_tuser;
            idx_reg  <= s_tdata[epfl_pkg::OP_W +: epfl_pkg::ENTRY_W];
        end
        sp_vrd_reg <= sp_vld_reg[sp_raddr];
        tr_vrd_reg <= tr_vld_reg[tr_raddr];
        if (cmd.commit) begin
            m_tdata_reg <= OUT_W'({status, slot});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_head_reg  <= '0;
            tr_head_reg  <= '0;
            sp_vld_reg   <= '0;
            tr_vld_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                sp_head_reg <= sp_head_next;
                tr_head_reg <= tr_head_next;
                sp_vld_reg  <= sp_vld_next;
                tr_vld_reg  <= tr_vld_next;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
